[rtl/core/oft_pkg.sv]
// Package for the operator flag table: sizes, types, opcodes and sequencer states.
`default_nettype none
package oft_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ID_WIDTH    = 16;
    localparam int FLAG_W      = 32;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    typedef logic [ID_WIDTH-1:0] t_id;
    typedef logic [FLAG_W-1:0]   t_flags;
    typedef logic [ADDR_W-1:0]   t_addr;
    typedef logic [CNT_W-1:0]    t_cnt;

    typedef struct packed {
        t_id    id;
        t_flags flags;
    } t_entry;

    typedef logic [1:0] t_op;
    localparam t_op OP_SET   = 2'd0;
    localparam t_op OP_GET   = 2'd1;
    localparam t_op OP_CLEAR = 2'd2;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SRCH,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

[rtl/core/operator_flag_table.sv]
// Operator flag table: bounded associative table of flag words with a global union.
//
// Input channel (i_valid / o_ready) takes one command word: opcode, operator id and
// flag bits. Output channel (o_valid / i_ready) returns one result word per command:
// the operator's flags, the union of all flags set since the last clear, and a
// status bit that is high when a set found the table full.
// A set or get scans the stored entries one per cycle through a single-port table
// memory and one id comparator; the scan stops at the first match or at the fill
// count. The table read is registered before the id compare, and a finished result
// passes from the sequencer's done state into the output register. A clear skips
// the scan and goes straight from the idle state to the done state.
// The block takes one command at a time: o_ready is high only while the sequencer
// is idle, so a next command can be taken in the same cycle the result appears.
// Reset empties the table (fill count to zero) and zeroes the union; the memory
// itself is not cleared, since only entries below the fill count are ever read.
// When the receiver stalls, a finished result waits in the output register while
// the next command is taken and searched; that command's result is held by the
// sequencer until the output register drains, and no command is taken meanwhile.
`default_nettype none
module operator_flag_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_opcode,
    input  wire logic [15:0] i_operator_id,
    input  wire logic [31:0] i_flag_bits,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_operator_flags,
    output logic [31:0]      o_union_flags,
    output logic             o_status
);

    oft_pkg::t_entry r_mem [oft_pkg::TABLE_DEPTH];

    oft_pkg::t_state r_state, n_state;
    oft_pkg::t_op    r_op, n_op;
    oft_pkg::t_id    r_id, n_id;
    oft_pkg::t_flags r_bits, n_bits;
    oft_pkg::t_cnt   r_idx, n_idx;
    oft_pkg::t_cnt   r_count, n_count;
    oft_pkg::t_flags r_union, n_union;
    logic            r_rd_vld, n_rd_vld;
    oft_pkg::t_addr  r_rd_addr, n_rd_addr;
    oft_pkg::t_entry r_rd_data;
    oft_pkg::t_flags r_res_flags, n_res_flags;
    logic            r_res_status, n_res_status;
    logic            r_out_vld, n_out_vld;
    oft_pkg::t_flags r_out_flags, n_out_flags;
    oft_pkg::t_flags r_out_union, n_out_union;
    logic            r_out_status, n_out_status;

    logic            rd_en;
    oft_pkg::t_addr  rd_addr;
    logic            wr_en;
    oft_pkg::t_addr  wr_addr;
    oft_pkg::t_entry wr_data;
    logic            hit;
    logic            scan_end;
    logic            accept;
    logic            out_load;

    assign o_ready  = (r_state == oft_pkg::ST_IDLE);
    assign accept   = i_valid && o_ready;
    assign hit      = r_rd_vld && (r_rd_data.id == r_id);
    assign scan_end = hit || (r_idx == r_count);
    assign out_load = !r_out_vld || i_ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            oft_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = (i_opcode == oft_pkg::OP_CLEAR) ? oft_pkg::ST_DONE
                                                              : oft_pkg::ST_SRCH;
                end
            end
            oft_pkg::ST_SRCH: begin
                if (scan_end) n_state = oft_pkg::ST_DONE;
            end
            oft_pkg::ST_DONE: begin
                if (out_load) n_state = oft_pkg::ST_IDLE;
            end
            default: n_state = oft_pkg::ST_IDLE;
        endcase
    end

    // datapath control
    always_comb begin
        n_op         = r_op;
        n_id         = r_id;
        n_bits       = r_bits;
        n_idx        = r_idx;
        n_count      = r_count;
        n_union      = r_union;
        n_rd_vld     = 1'b0;
        n_rd_addr    = r_rd_addr;
        n_res_flags  = r_res_flags;
        n_res_status = r_res_status;
        n_out_vld    = r_out_vld && !i_ready;
        n_out_flags  = r_out_flags;
        n_out_union  = r_out_union;
        n_out_status = r_out_status;
        rd_en        = 1'b0;
        rd_addr      = r_idx[oft_pkg::ADDR_W-1:0];
        wr_en        = 1'b0;
        wr_addr      = r_rd_addr;
        wr_data      = r_rd_data;
        case (r_state)
            oft_pkg::ST_IDLE: begin
                if (accept) begin
                    n_op   = i_opcode;
                    n_id   = oft_pkg::t_id'(i_operator_id);
                    n_bits = i_flag_bits;
                    n_idx  = '0;
                    if (i_opcode == oft_pkg::OP_CLEAR) begin
                        n_count      = '0;
                        n_union      = '0;
                        n_res_flags  = '0;
                        n_res_status = oft_pkg::STATUS_OK;
                    end else if (i_opcode == oft_pkg::OP_SET) begin
                        n_union = r_union | i_flag_bits;
                    end
                end
            end
            oft_pkg::ST_SRCH: begin
                // read of entry idx overlaps the compare of entry idx-1
                if (!scan_end) begin
                    rd_en     = 1'b1;
                    n_rd_vld  = 1'b1;
                    n_rd_addr = rd_addr;
                    n_idx     = r_idx + 1'b1;
                end else begin
                    n_res_status = oft_pkg::STATUS_OK;
                    if (hit) begin
                        if (r_op == oft_pkg::OP_SET) begin
                            wr_en         = 1'b1;
                            wr_addr       = r_rd_addr;
                            wr_data.id    = r_id;
                            wr_data.flags = r_rd_data.flags | r_bits;
                            n_res_flags   = r_rd_data.flags | r_bits;
                        end else begin
                            n_res_flags = r_rd_data.flags;
                        end
                    end else if (r_op == oft_pkg::OP_SET) begin
                        if (r_count == oft_pkg::t_cnt'(oft_pkg::TABLE_DEPTH)) begin
                            n_res_status = oft_pkg::STATUS_FULL;
                            n_res_flags  = '0;
                        end else begin
                            // new entry starts from zero flags
                            wr_en         = 1'b1;
                            wr_addr       = r_count[oft_pkg::ADDR_W-1:0];
                            wr_data.id    = r_id;
                            wr_data.flags = r_bits;
                            n_count       = r_count + 1'b1;
                            n_res_flags   = r_bits;
                        end
                    end else begin
                        n_res_flags = '0;
                    end
                end
            end
            oft_pkg::ST_DONE: begin
                if (out_load) begin
                    n_out_vld    = 1'b1;
                    n_out_flags  = r_res_flags;
                    n_out_union  = r_union;
                    n_out_status = r_res_status;
                end
            end
            default: begin
                n_out_vld = r_out_vld && !i_ready;
            end
        endcase
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= oft_pkg::ST_IDLE;
            r_count   <= '0;
            r_union   <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_union   <= n_union;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_id         <= n_id;
        r_bits       <= n_bits;
        r_idx        <= n_idx;
        r_rd_addr    <= n_rd_addr;
        r_res_flags  <= n_res_flags;
        r_res_status <= n_res_status;
        r_out_flags  <= n_out_flags;
        r_out_union  <= n_out_union;
        r_out_status <= n_out_status;
    end

    assign o_valid          = r_out_vld;
    assign o_operator_flags = r_out_flags;
    assign o_union_flags    = r_out_union;
    assign o_status         = r_out_status;

endmodule
`default_nettype wire
